### rtl/core/sxf_pkg.sv
// shared types and constants for the sprite xor framebuffer
package sxf_pkg;

    localparam int NUM_LANES = 8;
    localparam int COORD_W   = 8;
    localparam int MOD_IN_W  = 9;
    localparam int PADDR_W   = 4;

    localparam logic [1:0] FUNC_DRAW = 2'd0;
    localparam logic [1:0] FUNC_FILL = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    localparam logic [1:0] REG_RED   = 2'd0;
    localparam logic [1:0] REG_GREEN = 2'd1;
    localparam logic [1:0] REG_BLUE  = 2'd2;

    localparam logic [7:0] SCALE_RESET = 8'hff;

    typedef struct packed {
        logic               toggle;
        logic               prev;
        logic               clash;
        logic [COORD_W-1:0] col;
    } t_lane_out;

endpackage

### rtl/core/sxf_mod.sv
// two-stage modulo by a constant using a reciprocal multiply
module sxf_mod #(
    parameter int DIV = 64
) (
    input  logic                          i_clk,
    input  logic [sxf_pkg::MOD_IN_W-1:0]  i_v,
    output logic [sxf_pkg::COORD_W-1:0]   o_r
);
    localparam int SH  = 18;
    localparam int MUL = (1 << SH) / DIV + 1;
    localparam int PW  = sxf_pkg::MOD_IN_W + SH + 1;
    localparam int QW  = 2 * sxf_pkg::MOD_IN_W;

    logic [PW-1:0]                 prod;
    logic [sxf_pkg::MOD_IN_W-1:0]  r_q;
    logic [sxf_pkg::MOD_IN_W-1:0]  r_v;
    logic [QW-1:0]                 qd;
    logic [QW-1:0]                 rem;

    // floor(v / DIV) is exact for v below 512 with an 18-bit shift
    assign prod = PW'(i_v) * PW'(MUL);

    always_ff @(posedge i_clk) begin
        r_q <= prod[SH +: sxf_pkg::MOD_IN_W];
        r_v <= i_v;
    end

    assign qd  = QW'(r_q) * QW'(DIV);
    assign rem = QW'(r_v) - qd;

    always_ff @(posedge i_clk) begin
        o_r <= rem[sxf_pkg::COORD_W-1:0];
    end
endmodule

### rtl/core/sxf_lane.sv
// one sprite pixel: wrapped column, old pixel and collision test
module sxf_lane #(
    parameter int COLS = 64,
    parameter int LANE = 0
) (
    input  logic [COLS-1:0]              i_word,
    input  logic [sxf_pkg::COORD_W-1:0]  i_base,
    input  logic                         i_bit,
    output sxf_pkg::t_lane_out           o_lane
);
    localparam int CW = $clog2(COLS);
    localparam int SW = sxf_pkg::COORD_W + 1;

    logic [SW-1:0]               sum;
    logic [sxf_pkg::COORD_W-1:0] col;

    // base is already below COLS, so one subtract wraps it
    assign sum = SW'(i_base) + SW'(LANE);
    assign col = (sum >= SW'(COLS)) ? sxf_pkg::COORD_W'(sum - SW'(COLS))
                                    : sxf_pkg::COORD_W'(sum);

    always_comb begin
        o_lane.col    = col;
        o_lane.toggle = i_bit;
        o_lane.prev   = i_word[col[CW-1:0]];
        o_lane.clash  = i_word[col[CW-1:0]] & i_bit;
    end
endmodule

### rtl/core/sxf_merge.sv
// combines lane results into the new row word and the collision hit
module sxf_merge #(
    parameter int COLS = 64
) (
    input  logic [COLS-1:0]    i_word,
    input  sxf_pkg::t_lane_out i_lanes [sxf_pkg::NUM_LANES],
    output logic [COLS-1:0]    o_word,
    output logic               o_clash
);
    localparam int CW = $clog2(COLS);

    logic [COLS-1:0] mask;

    always_comb begin
        mask    = '0;
        o_clash = 1'b0;
        for (int l = 0; l < sxf_pkg::NUM_LANES; l++) begin
            if (i_lanes[l].toggle) begin
                mask[i_lanes[l].col[CW-1:0]] = 1'b1;
            end
            o_clash = o_clash | i_lanes[l].clash;
        end
    end

    assign o_word = i_word ^ mask;
endmodule

### rtl/core/sprite_xor_framebuffer.sv
// top level: monochrome xor sprite framebuffer with apb colour scales
//
// Input channel (i_in_valid / o_in_stall) takes one operation per transaction:
// draw one 8-bit sprite row by xor, fill the frame, or read one pixel.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// input transaction, in order. An accepted input passes through the states
// MODA and MODB of the constant modulo unit that wraps row and column, READ
// for the registered row read from the frame memory, and DONE for the eight
// lanes and the merge, where the result is registered; the block takes the
// next input only after DONE, so it handles one transaction at a time.
// A result waiting under i_out_stall does not block the next input; only
// its completion waits until the output register is free.
// The frame is kept as ROWS words of COLS bits with a valid bit per row;
// a row not yet written reads as the last fill value, so fill takes no
// sweep. After reset the frame reads all zero, the collision flag is clear
// and the three scales are 255; the block accepts input right away.
// Scales are written over apb at byte addresses 0, 4 and 8.
module sprite_xor_framebuffer #(
    parameter int COLS = 64,
    parameter int ROWS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_func,
    input  logic [7:0]                    i_start_col,
    input  logic [7:0]                    i_start_row,
    input  logic [3:0]                    i_row_index,
    input  logic [7:0]                    i_sprite_bits,
    input  logic                          i_last_row,
    input  logic                          i_fill_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_collision,
    output logic                          o_sprite_done,
    output logic                          o_pixel_value,
    output logic [7:0]                    o_red_out,
    output logic [7:0]                    o_green_out,
    output logic [7:0]                    o_blue_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sxf_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MW  = sxf_pkg::MOD_IN_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MODA = 3'd1;
    localparam logic [2:0] S_MODB = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]  r_state;
    logic [2:0]  n_state;

    logic [1:0]  r_func;
    logic [7:0]  r_scol;
    logic [7:0]  r_srow;
    logic [3:0]  r_ridx;
    logic [7:0]  r_bits;
    logic        r_last;
    logic        r_fill;

    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;

    logic        r_coll;
    logic        n_coll;
    logic        r_fill_val;
    logic [ROWS-1:0] r_row_vld;
    logic [COLS-1:0] r_frame [ROWS];
    logic [COLS-1:0] r_rd_word;
    logic        r_rd_vld;

    logic        r_out_valid;
    logic        r_o_coll;
    logic        r_o_done;
    logic        r_o_pix;
    logic [7:0]  r_o_red;
    logic [7:0]  r_o_green;
    logic [7:0]  r_o_blue;

    logic        in_acc;
    logic        cfg_wr;
    logic        finish;
    logic        is_draw;
    logic        is_read;
    logic        is_fill;
    logic        pix;
    logic        clash;
    logic [MW-1:0]   row_val;
    logic [7:0]      col_base;
    logic [7:0]      row_rem;
    logic [RAW-1:0]  row_idx;
    logic [COLS-1:0] word;
    logic [COLS-1:0] new_word;
    sxf_pkg::t_lane_out lanes [sxf_pkg::NUM_LANES];

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    // apb registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red   <= sxf_pkg::SCALE_RESET;
            r_green <= sxf_pkg::SCALE_RESET;
            r_blue  <= sxf_pkg::SCALE_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                sxf_pkg::REG_RED:   r_red   <= pwdata[7:0];
                sxf_pkg::REG_GREEN: r_green <= pwdata[7:0];
                sxf_pkg::REG_BLUE:  r_blue  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sxf_pkg::REG_RED:   prdata = {24'd0, r_red};
            sxf_pkg::REG_GREEN: prdata = {24'd0, r_green};
            sxf_pkg::REG_BLUE:  prdata = {24'd0, r_blue};
            default:            prdata = 32'd0;
        endcase
    end

    // input transaction capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func <= i_func;
            r_scol <= i_start_col;
            r_srow <= i_start_row;
            r_ridx <= i_row_index;
            r_bits <= i_sprite_bits;
            r_last <= i_last_row;
            r_fill <= i_fill_value;
        end
    end

    assign is_draw = (r_func == sxf_pkg::FUNC_DRAW);
    assign is_fill = (r_func == sxf_pkg::FUNC_FILL);
    assign is_read = (r_func == sxf_pkg::FUNC_READ);

    assign row_val = is_draw ? (MW'(r_srow) + MW'(r_ridx)) : MW'(r_srow);

    sxf_mod #(.DIV(COLS)) u_col_mod (
        .i_clk (i_clk),
        .i_v   (MW'(r_scol)),
        .o_r   (col_base)
    );

    sxf_mod #(.DIV(ROWS)) u_row_mod (
        .i_clk (i_clk),
        .i_v   (row_val),
        .o_r   (row_rem)
    );

    assign row_idx = row_rem[RAW-1:0];

    // frame memory, one row word per address
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_word <= r_frame[row_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish && is_draw) begin
            r_frame[row_idx] <= new_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (r_state == S_READ) begin
            r_rd_vld <= r_row_vld[row_idx];
        end
    end

    // rows never written since the last fill read as the fill value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld  <= '0;
            r_fill_val <= 1'b0;
        end else if (finish && is_fill) begin
            r_row_vld  <= '0;
            r_fill_val <= r_fill;
        end else if (finish && is_draw) begin
            r_row_vld[row_idx] <= 1'b1;
        end
    end

    assign word = r_rd_vld ? r_rd_word : {COLS{r_fill_val}};

    for (genvar l = 0; l < sxf_pkg::NUM_LANES; l++) begin : g_lane
        sxf_lane #(.COLS(COLS), .LANE(l)) u_lane (
            .i_word (word),
            .i_base (col_base),
            .i_bit  (r_bits[sxf_pkg::NUM_LANES-1-l]),
            .o_lane (lanes[l])
        );
    end

    sxf_merge #(.COLS(COLS)) u_merge (
        .i_word  (word),
        .i_lanes (lanes),
        .o_word  (new_word),
        .o_clash (clash)
    );

    // lane 0 sits on the start column, which is the pixel a read asks for
    assign pix    = lanes[0].prev;
    assign n_coll = ((r_ridx == 4'd0) ? 1'b0 : r_coll) | clash;
    assign finish = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coll <= 1'b0;
        end else if (finish && is_draw) begin
            r_coll <= n_coll;
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = in_acc ? S_MODA : S_IDLE;
            S_MODA:  n_state = S_MODB;
            S_MODB:  n_state = S_READ;
            S_READ:  n_state = S_DONE;
            S_DONE:  n_state = finish ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_o_coll  <= is_draw && n_coll;
            r_o_done  <= is_draw && r_last;
            r_o_pix   <= is_read && pix;
            r_o_red   <= (is_read && pix) ? r_red   : 8'd0;
            r_o_green <= (is_read && pix) ? r_green : 8'd0;
            r_o_blue  <= (is_read && pix) ? r_blue  : 8'd0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_collision   = r_o_coll;
    assign o_sprite_done = r_o_done;
    assign o_pixel_value = r_o_pix;
    assign o_red_out     = r_o_red;
    assign o_green_out   = r_o_green;
    assign o_blue_out    = r_o_blue;

    // an accepted transaction passes the modulo and read states to the completion state
    a_accept_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> ##4 (r_state == S_DONE))
        else $error("transaction did not reach completion on time");

    // a new result only ever comes out of the completion state
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result appeared outside completion");

    // a fill leaves every row reading as the fill value
    a_fill_clears_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && is_fill) |=> (r_row_vld == '0))
        else $error("row valid bits survived a fill");
endmodule

### dv/sxf_result_check.sv
// result checker for the sprite xor framebuffer: predicts each result and compares it
module sxf_result_check #(
    parameter int COLS = 64,
    parameter int ROWS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_stall,
    input  logic [1:0]                  i_func,
    input  logic [7:0]                  i_start_col,
    input  logic [7:0]                  i_start_row,
    input  logic [3:0]                  i_row_index,
    input  logic [7:0]                  i_sprite_bits,
    input  logic                        i_last_row,
    input  logic                        i_fill_value,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  logic                        o_collision,
    input  logic                        o_sprite_done,
    input  logic                        o_pixel_value,
    input  logic [7:0]                  o_red_out,
    input  logic [7:0]                  o_green_out,
    input  logic [7:0]                  o_blue_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sxf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic [31:0]                 prdata,
    input  logic                        pready,
    output int                          fail_count,
    output int                          pending_count
);

    typedef struct packed {
        logic       collision;
        logic       sprite_done;
        logic       pixel_value;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel_result;

    logic          frame_px [ROWS][COLS];
    logic          clash_flag;
    logic [7:0]    scale_r;
    logic [7:0]    scale_g;
    logic [7:0]    scale_b;
    t_pixel_result due_results [$];

    // updates the frame copy and returns the result the block should give
    function automatic t_pixel_result apply_op(
        input logic [1:0] func,
        input logic [7:0] scol,
        input logic [7:0] srow,
        input logic [3:0] ridx,
        input logic [7:0] bits,
        input logic       last,
        input logic       fill
    );
        t_pixel_result res;
        int            row;
        int            col;
        int            x;
        int            y;
        logic          prev;
        logic          p;
        res = '0;
        case (func)
            sxf_pkg::FUNC_DRAW: begin
                row = (int'(srow) + int'(ridx)) % ROWS;
                if (ridx == 4'd0) clash_flag = 1'b0;
                for (x = 0; x < 8; x++) begin
                    col = (int'(scol) + x) % COLS;
                    prev = frame_px[row][col];
                    frame_px[row][col] = prev ^ bits[7-x];
                    if (prev && bits[7-x]) clash_flag = 1'b1;
                end
                res.collision   = clash_flag;
                res.sprite_done = last;
            end
            sxf_pkg::FUNC_FILL: begin
                for (y = 0; y < ROWS; y++)
                    for (x = 0; x < COLS; x++)
                        frame_px[y][x] = fill;
            end
            sxf_pkg::FUNC_READ: begin
                p = frame_px[int'(srow) % ROWS][int'(scol) % COLS];
                res.pixel_value = p;
                res.red   = p ? scale_r : 8'd0;
                res.green = p ? scale_g : 8'd0;
                res.blue  = p ? scale_b : 8'd0;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    always @(posedge i_clk) begin
        t_pixel_result want;
        int            x;
        int            y;
        if (!i_rst_n) begin
            for (y = 0; y < ROWS; y++)
                for (x = 0; x < COLS; x++)
                    frame_px[y][x] = 1'b0;
            clash_flag = 1'b0;
            scale_r = sxf_pkg::SCALE_RESET;
            scale_g = sxf_pkg::SCALE_RESET;
            scale_b = sxf_pkg::SCALE_RESET;
            due_results.delete();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error("result transaction with no expected result waiting");
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    compare_field("collision",   {7'd0, want.collision},   {7'd0, o_collision});
                    compare_field("sprite_done", {7'd0, want.sprite_done}, {7'd0, o_sprite_done});
                    compare_field("pixel_value", {7'd0, want.pixel_value}, {7'd0, o_pixel_value});
                    compare_field("red_out",     want.red,   o_red_out);
                    compare_field("green_out",   want.green, o_green_out);
                    compare_field("blue_out",    want.blue,  o_blue_out);
                end
            end
            if (i_in_valid && !o_in_stall)
                due_results.push_back(apply_op(i_func, i_start_col, i_start_row, i_row_index,
                                               i_sprite_bits, i_last_row, i_fill_value));
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[sxf_pkg::PADDR_W-1:2])
                        sxf_pkg::REG_RED:   scale_r = pwdata[7:0];
                        sxf_pkg::REG_GREEN: scale_g = pwdata[7:0];
                        sxf_pkg::REG_BLUE:  scale_b = pwdata[7:0];
                        default: ;
                    endcase
                end else begin
                    // the spare address readback is not checked
                    case (paddr[sxf_pkg::PADDR_W-1:2])
                        sxf_pkg::REG_RED:   want.red = scale_r;
                        sxf_pkg::REG_GREEN: want.red = scale_g;
                        sxf_pkg::REG_BLUE:  want.red = scale_b;
                        default:            want.red = prdata[7:0];
                    endcase
                    if (paddr[sxf_pkg::PADDR_W-1:2] <= sxf_pkg::REG_BLUE &&
                        prdata !== {24'd0, want.red}) begin
                        $error("prdata mismatch: expected %0d, actual %0d", want.red, prdata);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = due_results.size();
    end

endmodule

### dv/tb_sprite_xor_framebuffer.sv
// testbench top for the sprite xor framebuffer: stimulus, idling and verdict
module tb_sprite_xor_framebuffer;

    localparam int         COLS      = 64;
    localparam int         ROWS      = 32;
    localparam int         PHASES    = 6;
    localparam int         PHASE_OPS = 250;
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] col;
        logic [7:0] row;
        logic [3:0] ridx;
        logic [7:0] bits;
        logic       last;
        logic       fill;
    } t_op;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic [1:0]                  i_func;
    logic [7:0]                  i_start_col;
    logic [7:0]                  i_start_row;
    logic [3:0]                  i_row_index;
    logic [7:0]                  i_sprite_bits;
    logic                        i_last_row;
    logic                        i_fill_value;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic                        o_collision;
    logic                        o_sprite_done;
    logic                        o_pixel_value;
    logic [7:0]                  o_red_out;
    logic [7:0]                  o_green_out;
    logic [7:0]                  o_blue_out;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [sxf_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    int                          fail_count;
    int                          pending_count;

    bit gaps_on  = 1'b1;
    bit stall_on = 1'b1;
    int draw_n;
    int fill_n;
    int read_n;
    int noise_n;
    int setting_n;

    sprite_xor_framebuffer #(.COLS(COLS), .ROWS(ROWS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_func(i_func), .i_start_col(i_start_col), .i_start_row(i_start_row),
        .i_row_index(i_row_index), .i_sprite_bits(i_sprite_bits),
        .i_last_row(i_last_row), .i_fill_value(i_fill_value),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_collision(o_collision), .o_sprite_done(o_sprite_done),
        .o_pixel_value(o_pixel_value), .o_red_out(o_red_out),
        .o_green_out(o_green_out), .o_blue_out(o_blue_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    sxf_result_check #(.COLS(COLS), .ROWS(ROWS)) u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_func(i_func), .i_start_col(i_start_col), .i_start_row(i_start_row),
        .i_row_index(i_row_index), .i_sprite_bits(i_sprite_bits),
        .i_last_row(i_last_row), .i_fill_value(i_fill_value),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_collision(o_collision), .o_sprite_done(o_sprite_done),
        .o_pixel_value(o_pixel_value), .o_red_out(o_red_out),
        .o_green_out(o_green_out), .o_blue_out(o_blue_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("FAILURE");
        $finish;
    end

    // receiver side: random bursts of output stall
    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_on && stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                if (stall_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 7);
            end
        end
    end

    function automatic t_op mk(input logic [1:0] func, input logic [7:0] col,
                               input logic [7:0] row, input logic [3:0] ridx,
                               input logic [7:0] bits, input logic last, input logic fill);
        t_op op;
        op = '{func, col, row, ridx, bits, last, fill};
        return op;
    endfunction

    function automatic t_op random_op();
        t_op op;
        op = t_op'($urandom);
        return op;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_op(input t_op op);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= op.func;
        i_start_col   <= op.col;
        i_start_row   <= op.row;
        i_row_index   <= op.ridx;
        i_sprite_bits <= op.bits;
        i_last_row    <= op.last;
        i_fill_value  <= op.fill;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        case (op.func)
            sxf_pkg::FUNC_DRAW: draw_n++;
            sxf_pkg::FUNC_FILL: fill_n++;
            sxf_pkg::FUNC_READ: read_n++;
            default:            noise_n++;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apb_access(input logic [1:0] idx, input logic write, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // drop valid and wait for every outstanding result, then a little longer
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic set_scales(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        apb_access(sxf_pkg::REG_RED,   1'b1, {24'($urandom_range(0, 32'hffffff)), r});
        apb_access(sxf_pkg::REG_GREEN, 1'b1, {24'($urandom_range(0, 32'hffffff)), g});
        apb_access(sxf_pkg::REG_BLUE,  1'b1, {24'($urandom_range(0, 32'hffffff)), b});
        apb_access(REG_SPARE,          1'b1, $urandom);
        apb_access(sxf_pkg::REG_RED,   1'b0, 32'd0);
        apb_access(sxf_pkg::REG_GREEN, 1'b0, 32'd0);
        apb_access(sxf_pkg::REG_BLUE,  1'b0, 32'd0);
        setting_n++;
    endtask

    task automatic run_random(input int n_ops);
        t_op base;
        t_op op;
        int  sent;
        int  kind;
        int  height;
        int  r;
        sent = 0;
        while (sent < n_ops) begin
            kind = $urandom_range(0, 99);
            base = random_op();
            if (kind < 60) begin
                // well-formed sprite, then reads inside its box
                height = ($urandom_range(0, 5) == 0) ? 16 : $urandom_range(1, 6);
                base.func = sxf_pkg::FUNC_DRAW;
                for (r = 0; r < height; r++) begin
                    op      = base;
                    op.ridx = 4'(r);
                    op.bits = 8'($urandom);
                    op.last = (r == height - 1);
                    op.fill = 1'($urandom);
                    send_op(op);
                end
                repeat (2) begin
                    op      = random_op();
                    op.func = sxf_pkg::FUNC_READ;
                    op.col  = base.col + 8'($urandom_range(0, 7));
                    op.row  = base.row + 8'($urandom_range(0, height - 1));
                    send_op(op);
                end
                sent += height + 2;
            end else if (kind < 85) begin
                base.func = sxf_pkg::FUNC_READ;
                send_op(base);
                sent++;
            end else if (kind < 93) begin
                // broken sprite: row index and last flag out of sequence
                base.func = sxf_pkg::FUNC_DRAW;
                send_op(base);
                sent++;
            end else if (kind < 97) begin
                base.func = FUNC_NONE;
                send_op(base);
            end else begin
                base.func = sxf_pkg::FUNC_FILL;
                send_op(base);
                sent++;
            end
        end
        drain();
    endtask

    initial begin
        int p;
        draw_n        = 0;
        fill_n        = 0;
        read_n        = 0;
        noise_n       = 0;
        setting_n     = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_func        = sxf_pkg::FUNC_DRAW;
        i_start_col   = '0;
        i_start_row   = '0;
        i_row_index   = '0;
        i_sprite_bits = '0;
        i_last_row    = 1'b0;
        i_fill_value  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values read back, spare address write must have no effect
        apb_access(sxf_pkg::REG_RED,   1'b0, 32'd0);
        apb_access(sxf_pkg::REG_GREEN, 1'b0, 32'd0);
        apb_access(sxf_pkg::REG_BLUE,  1'b0, 32'd0);
        apb_access(REG_SPARE,          1'b1, 32'hffff_ffff);
        apb_access(sxf_pkg::REG_BLUE,  1'b0, 32'd0);

        send_op(mk(sxf_pkg::FUNC_READ, 8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 1'b0));
        send_op(mk(sxf_pkg::FUNC_FILL, 8'ha5,  8'h5a,  4'hf,  8'hff, 1'b1, 1'b1));
        send_op(mk(sxf_pkg::FUNC_READ, 8'd63,  8'd31,  4'd0,  8'h00, 1'b0, 1'b0));
        send_op(mk(sxf_pkg::FUNC_READ, 8'd255, 8'd255, 4'hf,  8'hff, 1'b1, 1'b1));
        send_op(mk(sxf_pkg::FUNC_FILL, 8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 1'b0));
        // sprite wrapping across the right edge and the bottom edge
        send_op(mk(sxf_pkg::FUNC_DRAW, 8'd60,  8'd30,  4'd0,  8'hff, 1'b0, 1'b1));
        send_op(mk(sxf_pkg::FUNC_DRAW, 8'd60,  8'd30,  4'd1,  8'h81, 1'b0, 1'b0));
        send_op(mk(sxf_pkg::FUNC_DRAW, 8'd60,  8'd30,  4'd2,  8'h3c, 1'b0, 1'b0));
        send_op(mk(sxf_pkg::FUNC_DRAW, 8'd255, 8'd255, 4'hf,  8'haa, 1'b1, 1'b0));
        send_op(mk(sxf_pkg::FUNC_READ, 8'd60,  8'd30,  4'd0,  8'h00, 1'b0, 1'b0));
        send_op(mk(sxf_pkg::FUNC_READ, 8'd3,   8'd30,  4'd0,  8'h00, 1'b0, 1'b0));
        // redraw erases, collision raised, then sticky, then cleared at row 0
        send_op(mk(sxf_pkg::FUNC_DRAW, 8'd60,  8'd30,  4'd0,  8'hff, 1'b1, 1'b0));
        send_op(mk(sxf_pkg::FUNC_DRAW, 8'd0,   8'd0,   4'd5,  8'h00, 1'b0, 1'b0));
        send_op(mk(sxf_pkg::FUNC_DRAW, 8'd0,   8'd0,   4'd0,  8'h00, 1'b1, 1'b0));
        send_op(mk(FUNC_NONE,          8'd255, 8'd255, 4'hf,  8'hff, 1'b1, 1'b1));
        send_op(mk(sxf_pkg::FUNC_READ, 8'd62,  8'd31,  4'd0,  8'h00, 1'b0, 1'b0));
        send_op(mk(sxf_pkg::FUNC_READ, 8'd3,   8'd31,  4'd0,  8'h00, 1'b0, 1'b0));
        // fill keeps the flag, so a collision on a later row sets it
        send_op(mk(sxf_pkg::FUNC_FILL, 8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 1'b1));
        send_op(mk(sxf_pkg::FUNC_DRAW, 8'd10,  8'd5,   4'd3,  8'h80, 1'b0, 1'b0));
        send_op(mk(sxf_pkg::FUNC_READ, 8'd10,  8'd8,   4'd0,  8'h00, 1'b0, 1'b0));
        send_op(mk(sxf_pkg::FUNC_READ, 8'd11,  8'd8,   4'd0,  8'h00, 1'b0, 1'b0));
        send_op(mk(sxf_pkg::FUNC_DRAW, 8'd10,  8'd5,   4'd0,  8'h01, 1'b1, 1'b0));
        drain();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0:       set_scales(8'd0,   8'd0,   8'd0);
                1:       set_scales(8'd255, 8'd255, 8'd255);
                2:       set_scales(8'd1,   8'd128, 8'd127);
                default: set_scales(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            gaps_on  = (p != 3) && (p != PHASES - 1);
            stall_on = (p != 2) && (p != PHASES - 1);
            run_random(PHASE_OPS);
        end

        $display("covered %0d sprite rows, %0d fills, %0d pixel reads, %0d unused-selector ops",
                 draw_n, fill_n, read_n, noise_n);
        $display("over %0d colour scale settings with random input gaps and output stalls",
                 setting_n);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
